// ===== hdl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the solar charge current stepper: register
// map, configuration struct, reset values and field widths.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Field widths
  localparam int VOLT_W     = 16;
  localparam int CUR_W      = 16;
  localparam int SP_W       = 16;
  localparam int BAT_W      = 15;

  // Ring depth default
  localparam int DEFAULT_WINDOW = 5;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 5;
  localparam int REG_IDX_W  = PADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_V = 3'd0,
    REG_STEP     = 3'd1,
    REG_STAB     = 3'd2,
    REG_BAND_LO  = 3'd3,
    REG_BAND_HI  = 3'd4,
    REG_BAT_MIN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [VOLT_W-1:0] target_voltage_mv;
    logic [SP_W-1:0]   step_size_ma;
    logic [SP_W-1:0]   stability_threshold_ma;
    logic [VOLT_W-1:0] band_low_mv;
    logic [VOLT_W-1:0] band_high_mv;
    logic [BAT_W-1:0]  battery_min_current_ma;
  } cfg_t;

  // Reset values
  localparam logic [VOLT_W-1:0] RST_TARGET_V = 16'd5250;
  localparam logic [SP_W-1:0]   RST_STEP     = 16'd5;
  localparam logic [SP_W-1:0]   RST_STAB     = 16'd200;
  localparam logic [VOLT_W-1:0] RST_BAND_LO  = 16'd5000;
  localparam logic [VOLT_W-1:0] RST_BAND_HI  = 16'd5500;
  localparam logic [BAT_W-1:0]  RST_BAT_MIN  = 15'd60;

endpackage

// ===== hdl/scs_in_if.sv =====
// ----------------------------------------------------------------------------
// scs_in_if
// Sample channel: panel voltage and signed panel current, valid/ready.
// ----------------------------------------------------------------------------
interface scs_in_if;
  logic                              valid;
  logic                              ready;
  logic        [scs_pkg::VOLT_W-1:0] panel_voltage_mv;
  logic signed [scs_pkg::CUR_W-1:0]  panel_current_ma;

  modport source (output valid, output panel_voltage_mv, output panel_current_ma,
                  input ready);
  modport sink   (input valid, input panel_voltage_mv, input panel_current_ma,
                  output ready);
endinterface

// ===== hdl/scs_out_if.sv =====
// ----------------------------------------------------------------------------
// scs_out_if
// Result channel: charge current setpoint and hold flag, valid/ready.
// ----------------------------------------------------------------------------
interface scs_out_if;
  logic                       valid;
  logic                       ready;
  logic [scs_pkg::SP_W-1:0]   setpoint_ma;
  logic                       holding;

  modport source (output valid, output setpoint_ma, output holding, input ready);
  modport sink   (input valid, input setpoint_ma, input holding, output ready);
endinterface

// ===== hdl/scs_window_mem.sv =====
// ----------------------------------------------------------------------------
// scs_window_mem
// Ring of recent panel currents: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module scs_window_mem #(
  parameter int DEPTH = scs_pkg::DEFAULT_WINDOW,
  parameter int AW    = $clog2(scs_pkg::DEFAULT_WINDOW)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic        [AW-1:0]             wr_addr,
  input  logic signed [scs_pkg::CUR_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic        [AW-1:0]             rd_addr,
  output logic signed [scs_pkg::CUR_W-1:0] rd_data
);
  import scs_pkg::*;

  logic signed [CUR_W-1:0] mem [DEPTH];

  // Write the incoming sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/scs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scs_cfg_regs
// APB-style register file holding the regulation thresholds and step size.
// ----------------------------------------------------------------------------
module scs_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [scs_pkg::PADDR_W-1:0]        paddr,
  input  logic [scs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [scs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output scs_pkg::cfg_t                      cfg
);
  import scs_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_voltage_mv      <= RST_TARGET_V;
      cfg_r.step_size_ma           <= RST_STEP;
      cfg_r.stability_threshold_ma <= RST_STAB;
      cfg_r.band_low_mv            <= RST_BAND_LO;
      cfg_r.band_high_mv           <= RST_BAND_HI;
      cfg_r.battery_min_current_ma <= RST_BAT_MIN;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET_V: cfg_r.target_voltage_mv      <= pwdata[VOLT_W-1:0];
        REG_STEP:     cfg_r.step_size_ma           <= pwdata[SP_W-1:0];
        REG_STAB:     cfg_r.stability_threshold_ma <= pwdata[SP_W-1:0];
        REG_BAND_LO:  cfg_r.band_low_mv            <= pwdata[VOLT_W-1:0];
        REG_BAND_HI:  cfg_r.band_high_mv           <= pwdata[VOLT_W-1:0];
        REG_BAT_MIN:  cfg_r.battery_min_current_ma <= pwdata[BAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero-extended
  always_comb begin
    unique case (idx)
      REG_TARGET_V: prdata = CFG_DATA_W'(cfg_r.target_voltage_mv);
      REG_STEP:     prdata = CFG_DATA_W'(cfg_r.step_size_ma);
      REG_STAB:     prdata = CFG_DATA_W'(cfg_r.stability_threshold_ma);
      REG_BAND_LO:  prdata = CFG_DATA_W'(cfg_r.band_low_mv);
      REG_BAND_HI:  prdata = CFG_DATA_W'(cfg_r.band_high_mv);
      REG_BAT_MIN:  prdata = CFG_DATA_W'(cfg_r.battery_min_current_ma);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hdl/solar_charge_current_stepper.sv =====
// ----------------------------------------------------------------------------
// solar_charge_current_stepper
// Steps a charge current setpoint from panel voltage/current samples, using
// the spread and maximum of a ring of recent currents held in a memory.
//
//   channel  | direction | handshake         | payload
//   in_ch    | in        | valid/ready       | panel_voltage_mv, panel_current_ma
//   out_ch   | out       | valid/ready       | setpoint_ma, holding
//   apb      | in        | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// One sample at a time. With the ring not yet full a sample goes through accept
// and update. With the ring full it goes through accept, a read of every ring
// entry through the single read port of the ring memory, fold of the last
// entry, evaluate and update.
// Reset is synchronous; the ring memory is not cleared, it is read only once
// every entry has been written. A stalled output holds the update step until
// the result register frees; a new sample is taken while a result waits.
// ----------------------------------------------------------------------------
module solar_charge_current_stepper #(
  parameter int WINDOW = scs_pkg::DEFAULT_WINDOW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  scs_in_if.sink                         in_ch,
  scs_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scs_pkg::PADDR_W-1:0]    paddr,
  input  logic [scs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import scs_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW - 1);
  localparam logic [FW-1:0] FULL      = FW'(WINDOW);
  localparam logic [FW-1:0] MIN_FILL  = FW'(2);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_EVAL, S_UPD} state_t;
  typedef enum logic [1:0] {ACT_KEEP, ACT_DOWN, ACT_REG} act_t;

  cfg_t cfg;

  state_t                  state_r;
  act_t                    act_r;
  logic [AW-1:0]           wpos_r, wpos_inc;
  logic [FW-1:0]           fill_r, fill_inc;
  logic [AW-1:0]           scan_r;
  logic                    hold_r, hold_nxt;
  logic [SP_W-1:0]         sp_r, sp_nxt, sp_up, sp_dn;
  logic [SP_W:0]           up_sum;
  logic signed [CUR_W-1:0] mx_r, mn_r, mx_fold, mn_fold, rd_data;
  logic signed [CUR_W:0]   spread;
  logic                    in_band_r, above_r, bat_ok, stable;
  logic                    out_valid_r, out_hold_r, out_free, accept;
  logic [SP_W-1:0]         out_sp_r;

  scs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Writes happen only on accept (idle) and reads only while scanning, so
  // the two ports never touch the ring in the same cycle.
  scs_window_mem #(.DEPTH(WINDOW), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wpos_r),
    .wr_data (in_ch.panel_current_ma),
    .rd_en   (state_r == S_SCAN),
    .rd_addr (scan_r),
    .rd_data (rd_data)
  );

  // Handshake
  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.setpoint_ma = out_sp_r;
  assign out_ch.holding     = out_hold_r;

  // Ring pointer and fill count advance
  assign wpos_inc = (wpos_r == LAST_ADDR) ? '0 : wpos_r + 1'b1;
  assign fill_inc = (fill_r == FULL) ? fill_r : fill_r + 1'b1;

  // Fold read data into running max/min
  assign mx_fold = (rd_data > mx_r) ? rd_data : mx_r;
  assign mn_fold = (rd_data < mn_r) ? rd_data : mn_r;

  // Evaluate window: battery present and spread within threshold
  assign bat_ok = mx_r >= $signed({1'b0, cfg.battery_min_current_ma});
  assign spread = {mx_r[CUR_W-1], mx_r} - {mn_r[CUR_W-1], mn_r};
  assign stable = $unsigned(spread) <= {1'b0, cfg.stability_threshold_ma};

  // Saturating step up, clamped step down
  assign up_sum = {1'b0, sp_r} + {1'b0, cfg.step_size_ma};
  assign sp_up  = up_sum[SP_W] ? '1 : up_sum[SP_W-1:0];
  assign sp_dn  = (sp_r > cfg.step_size_ma) ? sp_r - cfg.step_size_ma : '0;

  // Next setpoint and hold flag
  always_comb begin
    sp_nxt   = sp_r;
    hold_nxt = hold_r;
    unique case (act_r)
      ACT_KEEP: ;
      ACT_DOWN: sp_nxt = sp_dn;
      ACT_REG: begin
        hold_nxt = in_band_r;
        if (!(hold_r && in_band_r)) begin
          sp_nxt = above_r ? sp_up : sp_dn;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_KEEP;
      wpos_r      <= '0;
      fill_r      <= '0;
      scan_r      <= '0;
      hold_r      <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result on an update, drop it once taken
      if ((state_r == S_UPD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            wpos_r    <= wpos_inc;
            fill_r    <= fill_inc;
            scan_r    <= '0;
            in_band_r <= (in_ch.panel_voltage_mv >= cfg.band_low_mv) &&
                         (in_ch.panel_voltage_mv <= cfg.band_high_mv);
            above_r   <= in_ch.panel_voltage_mv > cfg.target_voltage_mv;
            if (fill_inc == FULL) begin
              state_r <= S_SCAN;
            end else begin
              act_r   <= (fill_inc < MIN_FILL) ? ACT_KEEP : ACT_DOWN;
              state_r <= S_UPD;
            end
          end
        end
        S_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r == AW'(1)) begin
            mx_r <= rd_data;
            mn_r <= rd_data;
          end else if (scan_r != '0) begin
            mx_r <= mx_fold;
            mn_r <= mn_fold;
          end
          if (scan_r == LAST_ADDR) begin
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          mx_r    <= mx_fold;
          mn_r    <= mn_fold;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          act_r   <= !bat_ok ? ACT_KEEP : (stable ? ACT_REG : ACT_DOWN);
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            sp_r        <= sp_nxt;
            hold_r      <= hold_nxt;
            out_sp_r    <= sp_nxt;
            out_hold_r  <= hold_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Scan only runs over a fully written ring
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (fill_r == FULL))
    else $error("window scan started before ring was full");

  // Setpoint changes only in the update step
  a_sp_update_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_UPD) |=> $stable(sp_r))
    else $error("setpoint changed outside update step");

  // A new result comes only from the update step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result raised outside update step");

  // An accepted sample leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accepting a sample");

endmodule

// ===== tb/sv/tb_solar_charge_current_stepper.sv =====
// ----------------------------------------------------------------------------
// tb_solar_charge_current_stepper
// Self-checking bench for the solar charge current stepper. A queue of panel
// samples feeds a valid/ready driver, and a monitor compares each setpoint
// transaction with the oldest entry of a queue that a local setpoint
// predictor fills. A short directed run covers the fill phase, clamp and
// saturation, the hold band, an inverted band and the stability and battery
// limits. Random phases follow, each with a register setting and a pattern
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_solar_charge_current_stepper;
  import scs_pkg::*;

  localparam int RING_DEPTH    = DEFAULT_WINDOW;
  localparam int SETTLE_CYCLES = 2 * RING_DEPTH + 8;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 80;
  localparam int MAX_PRINTS    = 50;

  typedef struct {
    logic [VOLT_W-1:0]       volt;
    logic signed [CUR_W-1:0] cur;
  } panel_sample_t;

  typedef struct {
    logic [SP_W-1:0] setpoint_ma;
    logic            holding;
  } sp_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  scs_in_if  in_ch ();
  scs_out_if out_ch ();

  solar_charge_current_stepper #(.WINDOW(RING_DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and scoreboard
  panel_sample_t sample_q[$];
  sp_result_t    sp_expect_q[$];
  int            samples_queued = 0;
  int            samples_taken  = 0;
  int            mismatch_count = 0;
  int            src_idle_pct   = 0;
  int            dst_idle_pct   = 0;
  int            hold_left      = 0;
  int            cur_base       = 1000;

  // Predictor state and register mirror
  cfg_t                    live_cfg = '{target_voltage_mv:      RST_TARGET_V,
                                        step_size_ma:           RST_STEP,
                                        stability_threshold_ma: RST_STAB,
                                        band_low_mv:            RST_BAND_LO,
                                        band_high_mv:           RST_BAND_HI,
                                        battery_min_current_ma: RST_BAT_MIN};
  logic signed [CUR_W-1:0] cur_ring [RING_DEPTH];
  int                      ring_wr   = 0;
  int                      ring_fill = 0;
  logic                    hold_q    = 1'b0;
  logic [SP_W-1:0]         sp_q      = '0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  function automatic logic [SP_W-1:0] raise_setpoint(input logic [SP_W-1:0] v);
    logic [SP_W:0] sum;
    sum = {1'b0, v} + {1'b0, live_cfg.step_size_ma};
    return sum[SP_W] ? {SP_W{1'b1}} : sum[SP_W-1:0];
  endfunction

  function automatic logic [SP_W-1:0] lower_setpoint(input logic [SP_W-1:0] v);
    return (v > live_cfg.step_size_ma) ? v - live_cfg.step_size_ma : '0;
  endfunction

  // Advance the setpoint for one accepted sample and queue the expected result
  task automatic predict_setpoint(input logic [VOLT_W-1:0] volt,
                                  input logic signed [CUR_W-1:0] cur);
    int         mx;
    int         mn;
    logic       in_band;
    logic       frozen;
    sp_result_t res;
    in_band = (volt >= live_cfg.band_low_mv) && (volt <= live_cfg.band_high_mv);
    cur_ring[ring_wr] = cur;
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    if (ring_fill < RING_DEPTH) ring_fill++;
    if (ring_fill >= 2) begin
      if (ring_fill < RING_DEPTH) begin
        sp_q = lower_setpoint(sp_q);
      end else begin
        mx = int'(cur_ring[0]);
        mn = int'(cur_ring[0]);
        for (int i = 1; i < RING_DEPTH; i++) begin
          if (int'(cur_ring[i]) > mx) mx = int'(cur_ring[i]);
          if (int'(cur_ring[i]) < mn) mn = int'(cur_ring[i]);
        end
        // Hold the setpoint while no battery draws current
        if (mx >= int'(live_cfg.battery_min_current_ma)) begin
          if (mx - mn <= int'(live_cfg.stability_threshold_ma)) begin
            frozen = 1'b0;
            if (hold_q) begin
              if (in_band) frozen = 1'b1;
              else hold_q = 1'b0;
            end
            if (!frozen) begin
              if (volt > live_cfg.target_voltage_mv) sp_q = raise_setpoint(sp_q);
              else sp_q = lower_setpoint(sp_q);
              if (in_band) hold_q = 1'b1;
            end
          end else begin
            sp_q = lower_setpoint(sp_q);
          end
        end
      end
    end
    res.setpoint_ma = sp_q;
    res.holding     = hold_q;
    sp_expect_q.push_back(res);
  endtask

  // Sample driver: advance on each transaction, idle at random
  always @(posedge clk) begin : sample_driver
    panel_sample_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_setpoint(in_ch.panel_voltage_mv, in_ch.panel_current_ma);
        samples_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = sample_q.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.panel_voltage_mv <= nxt.volt;
          in_ch.panel_current_ma <= nxt.cur;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Result receiver: stall at random or during a hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Result monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin : result_monitor
    sp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sp_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 32'(out_ch.setpoint_ma));
      end else begin
        want = sp_expect_q.pop_front();
        if (out_ch.setpoint_ma !== want.setpoint_ma)
          report_mismatch("setpoint_ma", 32'(want.setpoint_ma), 32'(out_ch.setpoint_ma));
        if (out_ch.holding !== want.holding)
          report_mismatch("holding", 32'(want.holding), 32'(out_ch.holding));
      end
    end
  end

  task automatic queue_sample(input int volt, input int cur);
    panel_sample_t s;
    s.volt = volt[VOLT_W-1:0];
    s.cur  = cur[CUR_W-1:0];
    sample_q.push_back(s);
    samples_queued++;
  endtask

  // Drain: every sample taken, every result seen, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (samples_taken != samples_queued || sp_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, access cycle, junk in the unused upper bits
  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = {16'($urandom), value};
    if (idx == REG_BAT_MIN) data[15] = 1'($urandom_range(1));
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    case (idx)
      REG_TARGET_V: live_cfg.target_voltage_mv      = data[VOLT_W-1:0];
      REG_STEP:     live_cfg.step_size_ma           = data[SP_W-1:0];
      REG_STAB:     live_cfg.stability_threshold_ma = data[SP_W-1:0];
      REG_BAND_LO:  live_cfg.band_low_mv            = data[VOLT_W-1:0];
      REG_BAND_HI:  live_cfg.band_high_mv           = data[VOLT_W-1:0];
      REG_BAT_MIN:  live_cfg.battery_min_current_ma = data[BAT_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_cfg(input cfg_t c);
    cfg_write(REG_TARGET_V, c.target_voltage_mv);
    cfg_write(REG_STEP,     c.step_size_ma);
    cfg_write(REG_STAB,     c.stability_threshold_ma);
    cfg_write(REG_BAND_LO,  c.band_low_mv);
    cfg_write(REG_BAND_HI,  c.band_high_mv);
    cfg_write(REG_BAT_MIN,  {1'b0, c.battery_min_current_ma});
  endtask

  // Plausible setting around a random target; optionally an inverted band
  function automatic cfg_t pick_cfg(input bit invert_band);
    cfg_t c;
    int   target;
    target = 3000 + int'($urandom_range(0, 6000));
    c.target_voltage_mv      = target[15:0];
    c.step_size_ma           = 16'($urandom_range(1, 2000));
    c.stability_threshold_ma = 16'($urandom_range(0, 1500));
    c.band_low_mv            = 16'(target - int'($urandom_range(0, 1000)));
    c.band_high_mv           = 16'(target + int'($urandom_range(0, 1000)));
    c.battery_min_current_ma = 15'($urandom_range(0, 3000));
    if (invert_band) begin
      c.band_low_mv  = 16'(target + 1 + int'($urandom_range(0, 800)));
      c.band_high_mv = 16'(target - int'($urandom_range(0, 800)));
    end
    return c;
  endfunction

  // Mostly stable current clusters around the battery threshold, voltages
  // around the band and the target; a tenth is unshaped noise
  function automatic panel_sample_t make_sample();
    panel_sample_t s;
    int            v;
    int            c;
    int            lo;
    int            hi;
    int            span;
    if ($urandom_range(99) < 10) begin
      s.volt = 16'($urandom_range(0, 65535));
      s.cur  = 16'($urandom_range(0, 65535));
      return s;
    end
    if ($urandom_range(14) == 0)
      cur_base = int'(live_cfg.battery_min_current_ma) + int'($urandom_range(0, 600)) - 400;
    span = (int'(live_cfg.stability_threshold_ma) > 3000) ?
           3000 : int'(live_cfg.stability_threshold_ma);
    c = cur_base + int'($urandom_range(0, span));
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    lo = int'(live_cfg.band_low_mv);
    hi = int'(live_cfg.band_high_mv);
    case ($urandom_range(3))
      0, 1: v = lo - 40 + int'($urandom_range(0, ((hi > lo) ? hi - lo : 0) + 80));
      2:    v = int'(live_cfg.target_voltage_mv) - 20 + int'($urandom_range(0, 40));
      default: v = int'($urandom_range(0, 65535));
    endcase
    if (v > 65535) v = 65535;
    if (v < 0) v = 0;
    s.volt = v[15:0];
    s.cur  = c[15:0];
    return s;
  endfunction

  task automatic run_phase(input cfg_t c, input int src_pct, input int dst_pct,
                           input bit squeeze);
    wait_idle();
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    apply_cfg(c);
    @(negedge clk);
    repeat (PHASE_ITEMS) sample_q.push_back(make_sample());
    samples_queued += PHASE_ITEMS;
    // Stall the receiver while the sender keeps offering samples
    if (squeeze) hold_left = LONG_HOLD;
  endtask

  initial begin : stimulus
    cfg_t c;
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    in_ch.valid            = 1'b0;
    in_ch.panel_voltage_mv = '0;
    in_ch.panel_current_ma = '0;
    out_ch.ready           = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill phase with field extremes: unchanged, then clamped steps down
    queue_sample(6000, 1000);
    queue_sample(0, -32768);
    queue_sample(65535, 32767);
    queue_sample(5300, 1000);
    // Full ring with maximum spread, then flush the extremes out
    queue_sample(5300, 1000);
    repeat (3) queue_sample(6000, 1000);
    queue_sample(6000, 1000);
    // Enter the hold band, freeze, leave it, hit both inclusive edges
    queue_sample(5300, 1000);
    queue_sample(5100, 1000);
    queue_sample(4000, 1000);
    queue_sample(5000, 1000);
    queue_sample(5500, 1000);
    queue_sample(5501, 1000);
    // Window maximum below the battery threshold
    repeat (5) queue_sample(6000, 30);
    wait_idle();

    // Huge step for saturation and clamp, inverted band, no battery minimum
    cfg_write(REG_STEP, 16'hFFFF);
    cfg_write(REG_BAND_LO, 16'd6000);
    cfg_write(REG_BAND_HI, 16'd5000);
    cfg_write(REG_BAT_MIN, 16'd0);
    @(negedge clk);
    queue_sample(6000, 0);
    queue_sample(6000, 0);
    queue_sample(100, 0);
    queue_sample(6000, 0);
    // Spread exactly at the threshold, then one above it
    queue_sample(6000, 200);
    queue_sample(6000, 201);

    // Random phases
    c = '{RST_TARGET_V, RST_STEP, RST_STAB, RST_BAND_LO, RST_BAND_HI, RST_BAT_MIN};
    run_phase(c, 0, 0, 1'b0);
    run_phase(pick_cfg(1'b0), 70, 0, 1'b0);
    run_phase('0, 0, 70, 1'b0);
    c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF};
    run_phase(c, 7, 7, 1'b0);
    c.target_voltage_mv      = 16'($urandom_range(0, 65535));
    c.step_size_ma           = 16'($urandom_range(0, 65535));
    c.stability_threshold_ma = 16'($urandom_range(0, 65535));
    c.band_low_mv            = 16'($urandom_range(0, 65535));
    c.band_high_mv           = 16'($urandom_range(0, 65535));
    c.battery_min_current_ma = 15'($urandom_range(0, 32767));
    run_phase(c, 0, 0, 1'b1);
    run_phase(pick_cfg(1'b1), 70, 0, 1'b0);
    c = pick_cfg(1'b0);
    c.step_size_ma = 16'd20000;
    run_phase(c, 0, 70, 1'b0);
    c = '{RST_TARGET_V, RST_STEP, RST_STAB, RST_BAND_LO, RST_BAND_HI, RST_BAT_MIN};
    run_phase(c, 7, 7, 1'b0);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
